>>> rtl/weighted_random_pick_defines.svh
// Assertion macros for the weighted random pick block.
`ifndef WEIGHTED_RANDOM_PICK_DEFINES_SVH
`define WEIGHTED_RANDOM_PICK_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define WRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define WRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/wrp_pkg.sv
`default_nettype none

package wrp_pkg;

    localparam int VALUE_W   = 32;
    localparam int RND_W     = 31;
    localparam int MODE_W    = 2;
    localparam int SPAN_W    = 33;
    localparam int MOD_CNT_W = 5;

    localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RANGE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd2;

    localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_WALK_RD,
        ST_WALK_SUB,
        ST_VAL_RD,
        ST_VAL_WAIT,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

>>> rtl/wrp_if.sv
`default_nettype none

interface wrp_in_if;
    import wrp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] element_value;
    logic                      last_element;
    logic [RND_W-1:0]          random_word;

    modport source (output valid, element_value, last_element, random_word, input ready);
    modport sink   (input valid, element_value, last_element, random_word, output ready);
endinterface

interface wrp_out_if;
    import wrp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] picked_value;
    logic [MODE_W-1:0]         pick_mode;
    logic                      zero_weight_seen;

    modport source (output valid, picked_value, pick_mode, zero_weight_seen, input ready);
    modport sink   (input valid, picked_value, pick_mode, zero_weight_seen, output ready);
endinterface

`default_nettype wire

>>> rtl/weighted_random_pick.sv
// Loading: one element per cycle; the block is ready in every idle cycle.
// From the last element's transfer to a valid result: setup and finish for one element;
// setup, remainder steps and finish for two; for a weighted list, setup, remainder steps
// (none if not needed), a read and a subtract per pair walked, a value read, wait, finish.
// A finished result waits in the output register while the next list loads.
// Reset (async, active low) empties the list and the output; the store is not cleared.
`default_nettype none

`include "weighted_random_pick_defines.svh"

module weighted_random_pick #(
    parameter int MAX_ITEMS = 256
) (
    input wire logic  clk,
    input wire logic  rst_n,
    wrp_in_if.sink    elements,
    wrp_out_if.source result
);
    import wrp_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int RW = VALUE_W + 1 + $clog2(MAX_ITEMS);

    state_t state_reg, state_next;

    logic [CW-1:0]              count_reg, count_next;
    logic [VALUE_W-1:0]         sum_reg, sum_next;
    logic                       zflag_reg, zflag_next;
    logic signed [VALUE_W-1:0]  e0_reg, e0_next;
    logic signed [VALUE_W-1:0]  e1_reg, e1_next;
    logic [RND_W-1:0]           rnd_reg, rnd_next;
    logic [MODE_W-1:0]          mode_reg, mode_next;
    logic signed [VALUE_W-1:0]  lo_reg, lo_next;
    logic [CW:0]                idx_reg, idx_next;
    logic signed [RW-1:0]       roll_reg, roll_next;
    logic [AW-1:0]              vaddr_reg, vaddr_next;
    logic signed [VALUE_W-1:0]  pick_reg, pick_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [MODE_W-1:0]          out_mode_reg, out_mode_next;
    logic                       out_flag_reg, out_flag_next;

    logic                       accept;
    logic                       store;
    logic                       out_free;
    logic                       div_start;
    logic                       div_done;
    logic [SPAN_W-1:0]          div_divisor;
    logic [SPAN_W-1:0]          div_rem;
    logic [AW-1:0]              raddr;
    logic [VALUE_W-1:0]         rdata;
    logic signed [VALUE_W-1:0]  lo_w, hi_w;
    logic [SPAN_W-1:0]          span_w;
    logic signed [VALUE_W-1:0]  sum_s;
    logic signed [RW-1:0]       roll_dec;
    logic [CW-1:0]              last_pair;
    logic                       walk_more;

    assign accept   = elements.valid && elements.ready;
    assign store    = accept && (count_reg < CW'(MAX_ITEMS));
    assign out_free = !out_valid_reg || result.ready;

    assign lo_w      = (e0_reg < e1_reg) ? e0_reg : e1_reg;
    assign hi_w      = (e0_reg < e1_reg) ? e1_reg : e0_reg;
    assign span_w    = SPAN_W'({hi_w[VALUE_W-1], hi_w} - {lo_w[VALUE_W-1], lo_w} + 1'b1);
    assign sum_s     = sum_reg;
    assign roll_dec  = roll_reg - {{(RW-VALUE_W){rdata[VALUE_W-1]}}, rdata};
    // fall-through: trailing element for odd length, last pair's value for even
    assign last_pair = (count_reg - 1'b1) & ~CW'(1);
    assign walk_more = idx_reg < {1'b0, count_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && elements.last_element)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (count_reg <= CW'(1))
                begin
                    state_next = ST_FINISH;
                end
                else if (count_reg == CW'(2))
                begin
                    state_next = ST_DIV;
                end
                else if (sum_s <= 0 || sum_s == INT_MAX)
                begin
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = (mode_reg == MODE_RANGE) ? ST_FINISH : ST_WALK_RD;
                end
            end
            ST_WALK_RD:
            begin
                state_next = walk_more ? ST_WALK_SUB : ST_VAL_RD;
            end
            ST_WALK_SUB:
            begin
                state_next = (roll_dec <= 0) ? ST_VAL_RD : ST_WALK_RD;
            end
            ST_VAL_RD:
            begin
                state_next = ST_VAL_WAIT;
            end
            ST_VAL_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        elements.ready = 1'b0;
        div_start      = 1'b0;
        div_divisor    = {2'b00, sum_reg[VALUE_W-2:0]};
        raddr          = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                elements.ready = 1'b1;
            end
            ST_SETUP:
            begin
                if (count_reg == CW'(2))
                begin
                    div_start   = 1'b1;
                    div_divisor = span_w;
                end
                else if (count_reg > CW'(2) && sum_s > 0 && sum_s != INT_MAX)
                begin
                    div_start = 1'b1;
                end
            end
            ST_VAL_RD:
            begin
                raddr = vaddr_reg;
            end
            default:
            begin
                raddr = idx_reg[AW-1:0];
            end
        endcase
    end

    // datapath
    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        zflag_next     = zflag_reg;
        e0_next        = e0_reg;
        e1_next        = e1_reg;
        rnd_next       = rnd_reg;
        mode_next      = mode_reg;
        lo_next        = lo_reg;
        idx_next       = idx_reg;
        roll_next      = roll_reg;
        vaddr_next     = vaddr_reg;
        pick_next      = pick_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_mode_next  = out_mode_reg;
        out_flag_next  = out_flag_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (store)
                begin
                    count_next = count_reg + 1'b1;
                    if (count_reg == CW'(0))
                    begin
                        e0_next = elements.element_value;
                    end
                    if (count_reg == CW'(1))
                    begin
                        e1_next = elements.element_value;
                    end
                    if (count_reg[0])
                    begin
                        sum_next = sum_reg + elements.element_value;
                        if (elements.element_value == '0)
                        begin
                            zflag_next = 1'b1;
                        end
                    end
                end
                if (accept && elements.last_element)
                begin
                    rnd_next = elements.random_word;
                end
            end
            ST_SETUP:
            begin
                idx_next = (CW+1)'(1);
                lo_next  = lo_w;
                if (count_reg <= CW'(1))
                begin
                    mode_next = MODE_SINGLE;
                    pick_next = e0_reg;
                end
                else if (count_reg == CW'(2))
                begin
                    mode_next = MODE_RANGE;
                end
                else
                begin
                    mode_next = MODE_WEIGHTED;
                    if (sum_s <= 0)
                    begin
                        roll_next = RW'(1);
                    end
                    else if (sum_s == INT_MAX)
                    begin
                        roll_next = RW'({1'b0, rnd_reg}) + RW'(1);
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    pick_next = lo_reg + div_rem[VALUE_W-1:0];
                    roll_next = RW'(div_rem) + RW'(1);
                end
            end
            ST_WALK_RD:
            begin
                if (!walk_more)
                begin
                    vaddr_next = last_pair[AW-1:0];
                end
            end
            ST_WALK_SUB:
            begin
                roll_next = roll_dec;
                if (roll_dec <= 0)
                begin
                    vaddr_next = AW'(idx_reg - 1'b1);
                end
                else
                begin
                    idx_next = idx_reg + (CW+1)'(2);
                end
            end
            ST_VAL_RD:
            begin
                pick_next = pick_reg;
            end
            ST_VAL_WAIT:
            begin
                pick_next = rdata;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = pick_reg;
                    out_mode_next  = mode_reg;
                    out_flag_next  = (mode_reg == MODE_WEIGHTED) ? zflag_reg : 1'b0;
                    // drop the list for the next transfer sequence
                    count_next     = '0;
                    sum_next       = '0;
                    zflag_next     = 1'b0;
                end
            end
            default:
            begin
                pick_next = pick_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            zflag_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            zflag_reg     <= zflag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg        <= e0_next;
        e1_reg        <= e1_next;
        rnd_reg       <= rnd_next;
        mode_reg      <= mode_next;
        lo_reg        <= lo_next;
        idx_reg       <= idx_next;
        roll_reg      <= roll_next;
        vaddr_reg     <= vaddr_next;
        pick_reg      <= pick_next;
        out_value_reg <= out_value_next;
        out_mode_reg  <= out_mode_next;
        out_flag_reg  <= out_flag_next;
    end

    wrp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (store),
        .waddr (count_reg[AW-1:0]),
        .wdata (elements.element_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    wrp_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rnd_reg),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign result.valid            = out_valid_reg;
    assign result.picked_value     = out_value_reg;
    assign result.pick_mode        = out_mode_reg;
    assign result.zero_weight_seen = out_flag_reg;

    `WRP_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_ITEMS), "item count past limit")
    `WRP_ASSERT_IMPL(a_div_done_state, clk, rst_n, div_done, state_reg == ST_DIV, "remainder done outside wait state")
    `WRP_ASSERT_IMPL(a_walk_roll_pos, clk, rst_n, state_reg == ST_WALK_RD, roll_reg > 0, "walk continues with spent roll")
    `WRP_ASSERT_NEXT(a_out_load, clk, rst_n, state_reg == ST_FINISH && out_free, result.valid && state_reg == ST_IDLE, "result not loaded on finish")
endmodule

`default_nettype wire

>>> rtl/wrp_ram.sv
`default_nettype none

module wrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

>>> rtl/wrp_mod.sv
`default_nettype none

// Restoring remainder unit: one quotient bit per cycle.
module wrp_mod (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [wrp_pkg::RND_W-1:0]    dividend,
    input  wire logic [wrp_pkg::SPAN_W-1:0]   divisor,
    output logic                              done,
    output logic      [wrp_pkg::SPAN_W-1:0]   remainder
);
    import wrp_pkg::*;

    logic [SPAN_W-1:0]    rem_reg, rem_next;
    logic [RND_W-1:0]     dvd_reg, dvd_next;
    logic [SPAN_W-1:0]    div_reg, div_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SPAN_W:0]      shifted;
    logic [SPAN_W:0]      diff;

    assign shifted = {rem_reg, dvd_reg[RND_W-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            cnt_next  = MOD_CNT_W'(RND_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // subtract when the partial remainder reaches the divisor
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = diff[SPAN_W-1:0];
            end
            else
            begin
                rem_next = shifted[SPAN_W-1:0];
            end
            dvd_next = {dvd_reg[RND_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule

`default_nettype wire

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wrp_pkg::*;

    localparam int LIST_MAX      = 256;
    localparam int HALF_PERIOD   = 10;
    localparam int RANDOM_ITEMS  = 880;
    localparam int QUIET_FROM    = 800;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [MODE_W-1:0]         mode;
        logic                      zero_weight;
    } pick_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic [RND_W-1:0]          rnd;
        logic                      typed;
        pick_t                     want;
    } stim_row_t;

    localparam pick_t NO_PICK = '0;

    // Expected picks are typed only on the rows that close a list.
    localparam stim_row_t DIRECTED_ROWS [24] = '{
        // single element at both extremes
        '{32'sh8000_0000, 1'b1, 31'd0, 1'b1, '{32'sh8000_0000, MODE_SINGLE, 1'b0}},
        '{32'sh7FFF_FFFF, 1'b1, 31'd0, 1'b1, '{32'sh7FFF_FFFF, MODE_SINGLE, 1'b0}},
        // full-width range: min + (2^31 - 1) mod 2^32
        '{32'sh8000_0000, 1'b0, 31'd0,          1'b0, NO_PICK},
        '{32'sh7FFF_FFFF, 1'b1, 31'h7FFF_FFFF, 1'b1, '{-32'sd1, MODE_RANGE, 1'b0}},
        // range given high first
        '{32'sd10, 1'b0, 31'd0, 1'b0, NO_PICK},
        '{32'sd3,  1'b1, 31'd7, 1'b1, '{32'sd10, MODE_RANGE, 1'b0}},
        // zero weight in the list
        '{32'sd7, 1'b0, 31'd0, 1'b0, NO_PICK},
        '{32'sd0, 1'b0, 31'd0, 1'b0, NO_PICK},
        '{32'sd9, 1'b0, 31'd0, 1'b0, NO_PICK},
        '{32'sd1, 1'b1, 31'd0, 1'b1, '{32'sd9, MODE_WEIGHTED, 1'b1}},
        // negative sum, walk runs out on odd length: trailing element
        '{32'sd11,  1'b0, 31'd0,          1'b0, NO_PICK},
        '{-32'sd5,  1'b0, 31'd0,          1'b0, NO_PICK},
        '{32'sd22,  1'b1, 31'h5555_5555, 1'b1, '{32'sd22, MODE_WEIGHTED, 1'b0}},
        // walk runs out on even length: value of the last pair
        '{32'sd4,  1'b0, 31'd0,          1'b0, NO_PICK},
        '{-32'sd1, 1'b0, 31'd0,          1'b0, NO_PICK},
        '{32'sd8,  1'b0, 31'd0,          1'b0, NO_PICK},
        '{-32'sd1, 1'b1, 31'h2AAA_AAAA, 1'b1, '{32'sd8, MODE_WEIGHTED, 1'b0}},
        // sum equal to the largest positive value
        '{32'sd1,         1'b0, 31'd0,          1'b0, NO_PICK},
        '{32'sh7FFF_FFFF, 1'b0, 31'd0,          1'b0, NO_PICK},
        '{32'sd2,         1'b1, 31'h7FFF_FFFF, 1'b1, '{32'sd2, MODE_WEIGHTED, 1'b0}},
        // weight sum wraps negative
        '{32'sd3,         1'b0, 31'd0, 1'b0, NO_PICK},
        '{32'sh7FFF_FFFF, 1'b0, 31'd0, 1'b0, NO_PICK},
        '{32'sd6,         1'b0, 31'd0, 1'b0, NO_PICK},
        '{32'sd1,         1'b1, 31'd5, 1'b1, '{32'sd3, MODE_WEIGHTED, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    wrp_in_if  in_if();
    wrp_out_if out_if();

    weighted_random_pick #(
        .MAX_ITEMS(LIST_MAX)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .elements(in_if),
        .result  (out_if)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Predictor state
    logic signed [VALUE_W-1:0] elem_store [LIST_MAX];
    int unsigned               elem_count = 0;
    logic [VALUE_W-1:0]        weight_total = '0;
    bit                        saw_zero_weight = 1'b0;

    pick_t pending_picks [$];

    bit    row_has_expect = 1'b0;
    pick_t row_expect = NO_PICK;

    bit hold_results = 1'b0;
    bit quiet_tail = 1'b0;
    int gap_pct = 0;
    int sink_stall_pct = 0;

    int error_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int lists_sent = 0;
    int mode_hits [3] = '{0, 0, 0};

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %08h expected %08h (cycle %0d)",
                 field, got, want, cycle_count);
        error_count++;
    endtask

    // Take one element into the list; on the closing element compute the pick.
    task automatic absorb_element(input logic signed [VALUE_W-1:0] v, input bit is_last,
                                  input logic [RND_W-1:0] rnd, output bit produced,
                                  output pick_t res);
        longint      lo;
        longint      hi;
        longint      sum;
        longint      roll;
        longint      r;
        int unsigned n;
        int unsigned i;
        produced = 1'b0;
        res = NO_PICK;
        r = rnd;
        if (elem_count < LIST_MAX)
        begin
            elem_store[elem_count] = v;
            if (elem_count[0])
            begin
                weight_total += v;
                if (v == 0)
                    saw_zero_weight = 1'b1;
            end
            elem_count++;
        end
        if (!is_last)
            return;
        n = elem_count;
        produced = 1'b1;
        if (n <= 1)
        begin
            res.mode = MODE_SINGLE;
            res.value = elem_store[0];
        end
        else if (n == 2)
        begin
            lo = (elem_store[0] < elem_store[1]) ? elem_store[0] : elem_store[1];
            hi = (elem_store[0] < elem_store[1]) ? elem_store[1] : elem_store[0];
            res.mode = MODE_RANGE;
            res.value = VALUE_W'(lo + r % (hi - lo + 1));
        end
        else
        begin
            res.mode = MODE_WEIGHTED;
            res.zero_weight = saw_zero_weight;
            sum = $signed(weight_total);
            if (sum <= 0)
                roll = 1;
            else if (sum == longint'(INT_MAX))
                roll = r + 1;
            else
                roll = r % sum + 1;
            for (i = 1; i < n; i += 2)
            begin
                roll -= elem_store[i];
                if (roll <= 0)
                    break;
            end
            res.value = (i - 1 < n) ? elem_store[i - 1] : elem_store[n - 2];
        end
        elem_count = 0;
        weight_total = '0;
        saw_zero_weight = 1'b0;
    endtask

    // Track transfers on both channels at the rising edge.
    always @(posedge clk)
    begin : transfer_monitor
        bit    produced;
        pick_t predicted;
        pick_t want;
        if (rst_n)
        begin
            if (in_if.valid && in_if.ready)
            begin
                absorb_element(in_if.element_value, in_if.last_element, in_if.random_word,
                               produced, predicted);
                if (produced)
                    pending_picks.push_back(row_has_expect ? row_expect : predicted);
            end
            if (out_if.valid && out_if.ready)
            begin
                if (pending_picks.size() == 0)
                    report_mismatch("result with no pick pending", out_if.picked_value, '0);
                else
                begin
                    want = pending_picks.pop_front();
                    mode_hits[want.mode]++;
                    if (out_if.picked_value !== want.value)
                        report_mismatch("picked_value", out_if.picked_value, want.value);
                    if (out_if.pick_mode !== want.mode)
                        report_mismatch("pick_mode", 32'(out_if.pick_mode), 32'(want.mode));
                    if (out_if.zero_weight_seen !== want.zero_weight)
                        report_mismatch("zero_weight_seen", 32'(out_if.zero_weight_seen),
                                        32'(want.zero_weight));
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d picks outstanding",
                 cycle_count, pending_picks.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin : result_sink
        int burst;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_results = 1'b0;
                out_if.ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < sink_stall_pct)
            begin
                burst = $urandom_range(1, 14);
                out_if.ready <= 1'b0;
                repeat (burst) @(negedge clk);
                out_if.ready <= 1'b1;
            end
            else
                out_if.ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic offer_element(input logic signed [VALUE_W-1:0] v, input bit is_last,
                                 input logic [RND_W-1:0] rnd, input bit typed,
                                 input pick_t want);
        in_if.valid         <= 1'b1;
        in_if.element_value <= v;
        in_if.last_element  <= is_last;
        in_if.random_word   <= rnd;
        row_has_expect      <= typed;
        row_expect          <= want;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        @(negedge clk);
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    task automatic send_random_list(input int len, input bit well_formed);
        logic signed [VALUE_W-1:0] v;
        logic [RND_W-1:0]          rnd;
        for (int k = 0; k < len; k++)
        begin
            if (!well_formed)
                v = $urandom();
            else if (k % 2 == 0 || len <= 2)
            begin
                case ($urandom_range(0, 5))
                    0:       v = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    1:       v = $urandom_range(0, 200) - 100;
                    default: v = $urandom();
                endcase
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       v = 0;
                    1:       v = -$urandom_range(1, 20);
                    2:       v = $urandom();
                    default: v = $urandom_range(1, 40);
                endcase
            end
            case ($urandom_range(0, 7))
                0:       rnd = '0;
                1:       rnd = '1;
                default: rnd = RND_W'($urandom());
            endcase
            offer_element(v, k == len - 1, rnd, 1'b0, NO_PICK);
            items_sent++;
        end
        lists_sent++;
    endtask

    initial
    begin : stimulus
        int  len;
        bit  hold_done;
        bit  drain_done;
        bit  long_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        long_done  = 1'b0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.element_value = '0;
        in_if.last_element = 1'b0;
        in_if.random_word = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gap_pct = 20;
        sink_stall_pct = 10;
        foreach (DIRECTED_ROWS[r])
        begin
            offer_element(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].last,
                          DIRECTED_ROWS[r].rnd, DIRECTED_ROWS[r].typed,
                          DIRECTED_ROWS[r].want);
            if (DIRECTED_ROWS[r].last)
                lists_sent++;
        end

        while (items_sent < RANDOM_ITEMS)
        begin
            // vary idling by phase; one phase runs with no random gaps or stalls
            if (items_sent < 200)
            begin
                gap_pct = 25;
                sink_stall_pct = 10;
            end
            else if (items_sent < 400)
            begin
                gap_pct = 0;
                sink_stall_pct = 0;
            end
            else
            begin
                gap_pct = 10;
                sink_stall_pct = 20;
            end
            quiet_tail = (items_sent >= QUIET_FROM);

            if (!hold_done && items_sent >= 250)
            begin
                hold_results = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && items_sent >= 550)
            begin
                // hold off the input while the results drain
                in_if.valid <= 1'b0;
                while (pending_picks.size() != 0)
                    @(negedge clk);
                drain_done = 1'b1;
            end

            if (!long_done && items_sent >= 450)
            begin
                len = LIST_MAX + $urandom_range(1, 12);
                long_done = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       len = 1;
                    1:       len = 2;
                    default: len = $urandom_range(3, 14);
                endcase
            end
            send_random_list(len, $urandom_range(0, 4) != 0);
        end
        if (in_if.valid)
            in_if.valid <= 1'b0;

        while (pending_picks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d elements in %0d lists, including a list past the %0d-entry limit.",
                 items_sent + $size(DIRECTED_ROWS), lists_sent, LIST_MAX);
        $display("Checked picks: %0d single, %0d range, %0d weighted; %0d cycles.",
                 mode_hits[0], mode_hits[1], mode_hits[2], cycle_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
